// ===== src/lcd_lts_pkg.sv =====
// Shared types, constants and helpers for the LCD line timing sequencer.
`default_nettype none

package lcd_lts_pkg;

   // Phase lengths in ticks and line counts
   localparam logic [15:0] VISIBLE_TICKS = 16'd960;
   localparam logic [15:0] HBLANK_TICKS  = 16'd272;
   localparam logic [15:0] LINE_TICKS    = VISIBLE_TICKS + HBLANK_TICKS;
   localparam logic [7:0]  ACTIVE_LINE_COUNT = 8'd160;
   localparam logic [7:0]  BLANK_LINE_COUNT  = 8'd68;
   localparam logic [7:0]  FRAME_LINE_COUNT  = ACTIVE_LINE_COUNT + BLANK_LINE_COUNT;
   localparam logic [7:0]  VBLANK_CLEAR_LINE = 8'd227;
   localparam logic [7:0]  LINE_LAST     = FRAME_LINE_COUNT - 8'd1;

   // Field widths
   localparam int TICK_W = 10;
   localparam int ACC_W  = 16;
   localparam int LINE_W = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // Phase codes as seen on the result channel
   localparam logic [1:0] PHASE_CODE_VISIBLE = 2'd0;
   localparam logic [1:0] PHASE_CODE_HBLANK  = 2'd1;
   localparam logic [1:0] PHASE_CODE_VBLANK  = 2'd2;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_HBLANK_IRQ_EN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VBLANK_IRQ_EN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_IRQ_EN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_LINE    = 3'd3;

   typedef enum logic [2:0] {
      PH_VISIBLE = 3'b001,
      PH_HBLANK  = 3'b010,
      PH_VBLANK  = 3'b100
   } phase_type;

   typedef struct packed {
      logic              hblank_irq_enable;
      logic              vblank_irq_enable;
      logic              line_match_irq_enable;
      logic [LINE_W-1:0] match_line;
   } cfg_type;

   typedef struct packed {
      phase_type         phase;
      logic [ACC_W-1:0]  accum;
      logic [LINE_W-1:0] line;
      logic              hblank_bit;
      logic              vblank_bit;
      logic              match_bit;
      logic              vblank_level;
   } state_type;

   // Timing state after reset: visible phase, everything else cleared
   localparam state_type STATE_RESET = '{
      phase:        PH_VISIBLE,
      accum:        '0,
      line:         '0,
      hblank_bit:   1'b0,
      vblank_bit:   1'b0,
      match_bit:    1'b0,
      vblank_level: 1'b0
   };

   typedef struct packed {
      logic              frame_wrap_pulse;
      logic              vblank_signal;
      logic              frame_done_pulse;
      logic              draw_line_pulse;
      logic              match_irq;
      logic              vblank_irq;
      logic              hblank_irq;
      logic              match_flag;
      logic              vblank_flag;
      logic              hblank_flag;
      logic [LINE_W-1:0] line;
      logic [1:0]        phase;
   } result_type;

   localparam int RESULT_W = $bits(result_type);
   localparam int RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;
   localparam int REQ_DATA_W = ((TICK_W + 7) / 8) * 8;

   // Map the one-hot phase onto its external code
   function automatic logic [1:0] phase_code(input phase_type ph);
      logic [1:0] code;
      unique case (ph)
         PH_HBLANK: code = PHASE_CODE_HBLANK;
         PH_VBLANK: code = PHASE_CODE_VBLANK;
         default:   code = PHASE_CODE_VISIBLE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== src/lcd_lts_csr.sv =====
// Configuration registers of the LCD line timing sequencer.
`default_nettype none

module lcd_lts_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [lcd_lts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lcd_lts_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output lcd_lts_pkg::cfg_type                     cfg
);

   lcd_lts_pkg::cfg_type cfg_ff;
   lcd_lts_pkg::cfg_type cfg_in;

   // Decode the write; indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lcd_lts_pkg::CSR_HBLANK_IRQ_EN: cfg_in.hblank_irq_enable = csr_wdata[0];
            lcd_lts_pkg::CSR_VBLANK_IRQ_EN: cfg_in.vblank_irq_enable = csr_wdata[0];
            lcd_lts_pkg::CSR_MATCH_IRQ_EN:  cfg_in.line_match_irq_enable = csr_wdata[0];
            lcd_lts_pkg::CSR_MATCH_LINE:    cfg_in.match_line = csr_wdata[lcd_lts_pkg::LINE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/lcd_lts_step.sv =====
// Combinational timing step: accumulate ticks, take at most one phase transition.
`default_nettype none

module lcd_lts_step (
   input  wire lcd_lts_pkg::state_type           cur,
   input  wire lcd_lts_pkg::cfg_type             cfg,
   input  wire logic [lcd_lts_pkg::TICK_W-1:0]   tick_amount,
   output lcd_lts_pkg::state_type                nxt,
   output lcd_lts_pkg::result_type               res
);

   logic [lcd_lts_pkg::ACC_W:0]    sum;
   logic [lcd_lts_pkg::ACC_W-1:0]  acc_sat;
   logic [lcd_lts_pkg::LINE_W-1:0] line_inc;
   logic                           line_hit;
   logic                           hirq;
   logic                           virq;
   logic                           mirq;
   logic                           draw;
   logic                           done;
   logic                           wrap;

   // Saturating accumulate and the next line with its match compare
   assign sum = {1'b0, cur.accum}
              + {{(lcd_lts_pkg::ACC_W + 1 - lcd_lts_pkg::TICK_W){1'b0}}, tick_amount};
   assign acc_sat  = sum[lcd_lts_pkg::ACC_W] ? '1 : sum[lcd_lts_pkg::ACC_W-1:0];
   assign line_inc = cur.line + 8'd1;
   assign line_hit = (line_inc == cfg.match_line);

   // Phase transition
   always_comb begin
      nxt = cur;
      nxt.accum = acc_sat;
      hirq = 1'b0;
      virq = 1'b0;
      mirq = 1'b0;
      draw = 1'b0;
      done = 1'b0;
      wrap = 1'b0;
      unique case (cur.phase)
         lcd_lts_pkg::PH_HBLANK: begin
            if (acc_sat > lcd_lts_pkg::HBLANK_TICKS) begin
               nxt.accum      = acc_sat - lcd_lts_pkg::HBLANK_TICKS;
               nxt.hblank_bit = 1'b0;
               nxt.line       = line_inc;
               nxt.match_bit  = line_hit;
               mirq           = line_hit & cfg.line_match_irq_enable;
               if (line_inc >= lcd_lts_pkg::ACTIVE_LINE_COUNT) begin
                  nxt.phase        = lcd_lts_pkg::PH_VBLANK;
                  nxt.vblank_bit   = 1'b1;
                  nxt.vblank_level = 1'b1;
                  done             = 1'b1;
                  virq             = cfg.vblank_irq_enable;
               end else begin
                  nxt.phase = lcd_lts_pkg::PH_VISIBLE;
               end
            end
         end
         lcd_lts_pkg::PH_VBLANK: begin
            if (acc_sat > lcd_lts_pkg::LINE_TICKS) begin
               nxt.accum     = acc_sat - lcd_lts_pkg::LINE_TICKS;
               nxt.line      = line_inc;
               nxt.match_bit = line_hit;
               mirq          = line_hit & cfg.line_match_irq_enable;
               if (line_inc == lcd_lts_pkg::VBLANK_CLEAR_LINE) begin
                  nxt.vblank_bit = 1'b0;
               end
               // Wrap to the top of the frame
               if (line_inc >= lcd_lts_pkg::FRAME_LINE_COUNT) begin
                  nxt.line         = '0;
                  nxt.vblank_level = 1'b0;
                  nxt.phase        = lcd_lts_pkg::PH_VISIBLE;
                  wrap             = 1'b1;
               end
            end
         end
         default: begin
            if (acc_sat > lcd_lts_pkg::VISIBLE_TICKS) begin
               nxt.accum      = acc_sat - lcd_lts_pkg::VISIBLE_TICKS;
               nxt.phase      = lcd_lts_pkg::PH_HBLANK;
               nxt.hblank_bit = 1'b1;
               draw           = 1'b1;
               hirq           = cfg.hblank_irq_enable;
            end
         end
      endcase
   end

   // Assemble the result from the state after the step
   always_comb begin
      res.phase            = lcd_lts_pkg::phase_code(nxt.phase);
      res.line             = nxt.line;
      res.hblank_flag      = nxt.hblank_bit;
      res.vblank_flag      = nxt.vblank_bit;
      res.match_flag       = nxt.match_bit;
      res.hblank_irq       = hirq;
      res.vblank_irq       = virq;
      res.match_irq        = mirq;
      res.draw_line_pulse  = draw;
      res.frame_done_pulse = done;
      res.vblank_signal    = nxt.vblank_level;
      res.frame_wrap_pulse = wrap;
   end

endmodule

`default_nettype wire

// ===== src/lcd_line_timing_sequencer.sv =====
// Top level of the LCD line timing sequencer: input register, timing state, result register.
// A request is captured in the input register and stepped into the result register, from
// which its result is offered on the result channel.
// Throughput: one item per cycle; the input stalls only while a held result is not taken.
// Reset (synchronous, active high) clears both registers' valid bits, the timing state
// and the configuration registers; no clearing pass.
`default_nettype none

module lcd_line_timing_sequencer (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request channel; tdata: tick_amount[9:0], zero fill
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [lcd_lts_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Result channel; tdata: phase[1:0], line[9:2], hblank_flag[10], vblank_flag[11],
   // match_flag[12], hblank_irq[13], vblank_irq[14], match_irq[15], draw_line_pulse[16],
   // frame_done_pulse[17], vblank_signal[18], frame_wrap_pulse[19], zero fill
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [lcd_lts_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // Configuration write port
   input  wire logic                                 csr_we,
   input  wire logic [lcd_lts_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [lcd_lts_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   lcd_lts_pkg::cfg_type    cfg;
   lcd_lts_pkg::state_type  state_ff;
   lcd_lts_pkg::state_type  state_in;
   lcd_lts_pkg::result_type step_res;
   lcd_lts_pkg::result_type out_ff;

   logic                            in_valid_ff;
   logic [lcd_lts_pkg::TICK_W-1:0]  in_tick_ff;
   logic                            out_valid_ff;
   logic                            step_fire;

   lcd_lts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lcd_lts_step u_step (
      .cur         (state_ff),
      .cfg         (cfg),
      .tick_amount (in_tick_ff),
      .nxt         (state_in),
      .res         (step_res)
   );

   // Advance when an item waits and the result register is free or draining
   assign step_fire  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_fire;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_tick_ff <= req_tdata[lcd_lts_pkg::TICK_W-1:0];
      end
   end

   // Timing state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcd_lts_pkg::STATE_RESET;
      end else if (step_fire) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         out_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(lcd_lts_pkg::RSP_DATA_W - lcd_lts_pkg::RESULT_W){1'b0}}, out_ff};

   // Line counter stays inside the frame
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.line <= lcd_lts_pkg::LINE_LAST)
      else $error("line counter beyond last line");

   // Vblank level tracks the vblank phase
   a_vlevel_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff.vblank_level == (state_ff.phase == lcd_lts_pkg::PH_VBLANK))
      else $error("vblank level out of step with phase");

   // A wrap leaves the counter at line 0 in the visible phase
   a_wrap_state: assert property (@(posedge clock) disable iff (reset)
      step_fire && step_res.frame_wrap_pulse |=>
         state_ff.line == '0 && state_ff.phase == lcd_lts_pkg::PH_VISIBLE)
      else $error("wrap did not return to line 0");

   // The accumulator only moves when an item is stepped
   a_accum_hold: assert property (@(posedge clock) disable iff (reset)
      !step_fire |=> $stable(state_ff.accum))
      else $error("accumulator changed without a step");

   // A stepped item always produces a pending result
   a_result_pending: assert property (@(posedge clock) disable iff (reset)
      step_fire |=> rsp_tvalid)
      else $error("stepped item lost its result");

endmodule

`default_nettype wire

// ===== tb/lcd_line_timing_sequencer_test.sv =====
// Self-checking testbench for the LCD line timing sequencer.
`default_nettype none

module lcd_line_timing_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [lcd_lts_pkg::TICK_W-1:0] TICK_MAX = {lcd_lts_pkg::TICK_W{1'b1}};
   localparam logic [lcd_lts_pkg::CSR_INDEX_W-1:0] CSR_FIRST_UNUSED =
      lcd_lts_pkg::CSR_MATCH_LINE + 1'b1;
   localparam int MAX_PRINTED = 100;

   // Timing model: tracks the line sequencer state and the expected status words
   class line_status_model;
      lcd_lts_pkg::cfg_type    csr;
      lcd_lts_pkg::state_type  st;
      lcd_lts_pkg::result_type pending_status[$];
      int         error_count;
      int         status_count;

      function new();
         csr = '0;
         st = lcd_lts_pkg::STATE_RESET;
         error_count = 0;
         status_count = 0;
      endfunction

      task report_mismatch(string what);
         error_count++;
         if (error_count <= MAX_PRINTED)
            $display("mismatch at %0t ns, status %0d: %s", $time, status_count, what);
      endtask

      // Apply a register write; bits above a register's width drop out
      function void write_reg(logic [lcd_lts_pkg::CSR_INDEX_W-1:0] index,
                              logic [lcd_lts_pkg::CSR_DATA_W-1:0] data);
         case (index)
            lcd_lts_pkg::CSR_HBLANK_IRQ_EN: csr.hblank_irq_enable = data[0];
            lcd_lts_pkg::CSR_VBLANK_IRQ_EN: csr.vblank_irq_enable = data[0];
            lcd_lts_pkg::CSR_MATCH_IRQ_EN:  csr.line_match_irq_enable = data[0];
            lcd_lts_pkg::CSR_MATCH_LINE:    csr.match_line = data[lcd_lts_pkg::LINE_W-1:0];
            default: ;
         endcase
      endfunction

      // Advance the line counter, refresh the match bit, return the match pulse
      function logic bump_line();
         st.line = st.line + 8'd1;
         st.match_bit = (st.line == csr.match_line);
         return st.match_bit & csr.line_match_irq_enable;
      endfunction

      // Step the timing state for one accepted tick batch and queue its status
      function void note_ticks(logic [lcd_lts_pkg::TICK_W-1:0] ticks);
         lcd_lts_pkg::result_type       r;
         logic [lcd_lts_pkg::ACC_W:0]   sum;
         r = '0;
         sum = {1'b0, st.accum}
             + {{(lcd_lts_pkg::ACC_W + 1 - lcd_lts_pkg::TICK_W){1'b0}}, ticks};
         st.accum = sum[lcd_lts_pkg::ACC_W] ? {lcd_lts_pkg::ACC_W{1'b1}}
                                            : sum[lcd_lts_pkg::ACC_W-1:0];
         case (st.phase)
            lcd_lts_pkg::PH_HBLANK: begin
               if (st.accum > lcd_lts_pkg::HBLANK_TICKS) begin
                  st.accum = st.accum - lcd_lts_pkg::HBLANK_TICKS;
                  st.hblank_bit = 1'b0;
                  r.match_irq = bump_line();
                  if (st.line >= lcd_lts_pkg::ACTIVE_LINE_COUNT) begin
                     st.phase = lcd_lts_pkg::PH_VBLANK;
                     r.frame_done_pulse = 1'b1;
                     st.vblank_bit = 1'b1;
                     r.vblank_irq = csr.vblank_irq_enable;
                     st.vblank_level = 1'b1;
                  end else begin
                     st.phase = lcd_lts_pkg::PH_VISIBLE;
                  end
               end
            end
            lcd_lts_pkg::PH_VBLANK: begin
               if (st.accum > lcd_lts_pkg::LINE_TICKS) begin
                  st.accum = st.accum - lcd_lts_pkg::LINE_TICKS;
                  r.match_irq = bump_line();
                  if (st.line == lcd_lts_pkg::VBLANK_CLEAR_LINE)
                     st.vblank_bit = 1'b0;
                  // wrap back to the top of the frame
                  if (st.line >= lcd_lts_pkg::FRAME_LINE_COUNT) begin
                     st.line = '0;
                     r.frame_wrap_pulse = 1'b1;
                     st.vblank_level = 1'b0;
                     st.phase = lcd_lts_pkg::PH_VISIBLE;
                  end
               end
            end
            default: begin
               if (st.accum > lcd_lts_pkg::VISIBLE_TICKS) begin
                  st.accum = st.accum - lcd_lts_pkg::VISIBLE_TICKS;
                  st.phase = lcd_lts_pkg::PH_HBLANK;
                  r.draw_line_pulse = 1'b1;
                  st.hblank_bit = 1'b1;
                  r.hblank_irq = csr.hblank_irq_enable;
               end
            end
         endcase
         case (st.phase)
            lcd_lts_pkg::PH_HBLANK: r.phase = lcd_lts_pkg::PHASE_CODE_HBLANK;
            lcd_lts_pkg::PH_VBLANK: r.phase = lcd_lts_pkg::PHASE_CODE_VBLANK;
            default:                r.phase = lcd_lts_pkg::PHASE_CODE_VISIBLE;
         endcase
         r.line = st.line;
         r.hblank_flag = st.hblank_bit;
         r.vblank_flag = st.vblank_bit;
         r.match_flag = st.match_bit;
         r.vblank_signal = st.vblank_level;
         pending_status.push_back(r);
      endfunction

      task match_field(string field_name, int got, int want);
         if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", field_name, got, want));
      endtask

      // Compare one status transfer with the oldest expectation
      task check_status(logic [lcd_lts_pkg::RSP_DATA_W-1:0] data);
         lcd_lts_pkg::result_type got;
         lcd_lts_pkg::result_type want;
         got = lcd_lts_pkg::result_type'(data[lcd_lts_pkg::RESULT_W-1:0]);
         if (pending_status.size() == 0) begin
            report_mismatch("status transfer with nothing expected");
            return;
         end
         want = pending_status.pop_front();
         match_field("phase", got.phase, want.phase);
         match_field("line", got.line, want.line);
         match_field("hblank_flag", got.hblank_flag, want.hblank_flag);
         match_field("vblank_flag", got.vblank_flag, want.vblank_flag);
         match_field("match_flag", got.match_flag, want.match_flag);
         match_field("hblank_irq", got.hblank_irq, want.hblank_irq);
         match_field("vblank_irq", got.vblank_irq, want.vblank_irq);
         match_field("match_irq", got.match_irq, want.match_irq);
         match_field("draw_line_pulse", got.draw_line_pulse, want.draw_line_pulse);
         match_field("frame_done_pulse", got.frame_done_pulse, want.frame_done_pulse);
         match_field("vblank_signal", got.vblank_signal, want.vblank_signal);
         match_field("frame_wrap_pulse", got.frame_wrap_pulse, want.frame_wrap_pulse);
         match_field("zero fill",
                     data[lcd_lts_pkg::RSP_DATA_W-1:lcd_lts_pkg::RESULT_W], 0);
         status_count++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [lcd_lts_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [lcd_lts_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [lcd_lts_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [lcd_lts_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int req_gap_pct = 0;
   int rsp_stall_pct = 0;

   line_status_model status_model;

   lcd_line_timing_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Stall the status channel at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watch both channels: note tick transfers first, then check status transfers
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            status_model.note_ticks(req_tdata[lcd_lts_pkg::TICK_W-1:0]);
         if (rsp_tvalid && rsp_tready)
            status_model.check_status(rsp_tdata);
      end
   end

   // Offer one tick batch, with an optional gap ahead of it, and hold until transfer
   task automatic send_ticks(input logic [lcd_lts_pkg::TICK_W-1:0] ticks);
      if ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(lcd_lts_pkg::REQ_DATA_W-lcd_lts_pkg::TICK_W){1'b0}}, ticks};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drain the block, then write all registers plus one unused index
   task automatic set_config(input logic hb_en, input logic vb_en, input logic match_en,
                             input logic [lcd_lts_pkg::LINE_W-1:0] line_sel);
      logic [lcd_lts_pkg::CSR_INDEX_W-1:0] idx [5];
      logic [lcd_lts_pkg::CSR_DATA_W-1:0]  val [5];
      req_tvalid <= 1'b0;
      // the last tick transfer is noted by the monitor at this edge, so look after it
      do @(posedge clock); while (status_model.pending_status.size() != 0);
      repeat (4) @(posedge clock);
      idx[0] = CSR_FIRST_UNUSED + 3'($urandom_range(3));
      val[0] = lcd_lts_pkg::CSR_DATA_W'($urandom);
      idx[1] = lcd_lts_pkg::CSR_HBLANK_IRQ_EN;
      val[1] = (lcd_lts_pkg::CSR_DATA_W'($urandom) & ~lcd_lts_pkg::CSR_DATA_W'(1)) | hb_en;
      idx[2] = lcd_lts_pkg::CSR_VBLANK_IRQ_EN;
      val[2] = (lcd_lts_pkg::CSR_DATA_W'($urandom) & ~lcd_lts_pkg::CSR_DATA_W'(1)) | vb_en;
      idx[3] = lcd_lts_pkg::CSR_MATCH_IRQ_EN;
      val[3] = (lcd_lts_pkg::CSR_DATA_W'($urandom) & ~lcd_lts_pkg::CSR_DATA_W'(1))
             | match_en;
      idx[4] = lcd_lts_pkg::CSR_MATCH_LINE;
      val[4] = line_sel;
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         status_model.write_reg(idx[i], val[i]);
      end
      csr_we <= 1'b0;
   endtask

   // Random tick traffic in bursts; an overload run saturates the accumulator, then drains it
   task automatic run_segment(input int item_goal, input bit with_overload);
      int sent;
      int kind;
      int burst_len;
      logic [lcd_lts_pkg::TICK_W-1:0] ticks;
      sent = 0;
      if (with_overload) begin
         repeat (360) send_ticks(TICK_MAX);
         repeat (90) send_ticks('0);
         sent = 450;
      end
      while (sent < item_goal) begin
         kind = $urandom_range(9);
         burst_len = $urandom_range(1, 30);
         for (int k = 0; k < burst_len; k++) begin
            case (kind)
               5: ticks = TICK_MAX;
               6: ticks = lcd_lts_pkg::TICK_W'($urandom_range(15));
               7: ticks = '0;
               8: begin
                  case ($urandom_range(5))
                     0: ticks = lcd_lts_pkg::TICK_W'(lcd_lts_pkg::HBLANK_TICKS - 1);
                     1: ticks = lcd_lts_pkg::TICK_W'(lcd_lts_pkg::HBLANK_TICKS);
                     2: ticks = lcd_lts_pkg::TICK_W'(lcd_lts_pkg::HBLANK_TICKS + 1);
                     3: ticks = lcd_lts_pkg::TICK_W'(lcd_lts_pkg::VISIBLE_TICKS - 1);
                     4: ticks = lcd_lts_pkg::TICK_W'(lcd_lts_pkg::VISIBLE_TICKS);
                     default: ticks = lcd_lts_pkg::TICK_W'(lcd_lts_pkg::VISIBLE_TICKS + 1);
                  endcase
               end
               9: ticks = lcd_lts_pkg::TICK_W'($urandom_range(1023, 512));
               default: ticks = lcd_lts_pkg::TICK_W'($urandom);
            endcase
            send_ticks(ticks);
            sent++;
         end
      end
   endtask

   // Main sequence
   initial begin
      logic [lcd_lts_pkg::TICK_W-1:0] directed_ticks [16];
      int n;
      status_model = new();
      directed_ticks = '{10'd0, 10'd960, 10'd1, 10'd271, 10'd1, 10'd1023, 10'd0, 10'd1023,
                         10'h2AA, 10'h155, 10'd1023, 10'd1023, 10'd512, 10'd0, 10'd1,
                         10'd1023};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: threshold edges, field extremes, alternating bit patterns
      req_gap_pct = 30;
      rsp_stall_pct = 59;
      set_config(1'b1, 1'b1, 1'b1, 8'd1);
      foreach (directed_ticks[i]) send_ticks(directed_ticks[i]);

      // Random phases, each under its own register setting, in pairs that share an idle profile
      set_config(1'b0, 1'b0, 1'b0, 8'd0);
      run_segment(260, 1'b0);
      set_config(1'b1, 1'b1, 1'b1, 8'd228);
      run_segment(450, 1'b1);
      req_gap_pct = 59;
      rsp_stall_pct = 30;
      set_config(1'b1, 1'b0, 1'b1, 8'd255);
      run_segment(260, 1'b0);
      set_config(1'b0, 1'b1, 1'b1, 8'd160);
      run_segment(260, 1'b0);
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      set_config(1'b1, 1'b1, 1'b0, 8'd227);
      run_segment(450, 1'b1);
      set_config(1'($urandom), 1'($urandom), 1'b1,
                 lcd_lts_pkg::LINE_W'($urandom_range(227)));
      run_segment(260, 1'b0);
      req_tvalid <= 1'b0;

      // Let outstanding status words arrive, then a short settle
      n = 0;
      do begin
         @(posedge clock);
         n++;
      end while (status_model.pending_status.size() != 0 && n < 5000);
      repeat (8) @(posedge clock);
      if (status_model.pending_status.size() != 0)
         status_model.report_mismatch($sformatf("%0d expected status words never arrived",
                                                status_model.pending_status.size()));
      if (status_model.error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
src/lcd_lts_pkg.sv
src/lcd_lts_csr.sv
src/lcd_lts_step.sv
src/lcd_line_timing_sequencer.sv
tb/lcd_line_timing_sequencer_test.sv
